FILE: src/key_press_classifier_macros.svh
// ----------------------------------------------------------------------------
// key_press_classifier_macros.svh
// Assertion macros used by the key press classifier top level.
// ----------------------------------------------------------------------------
`ifndef KEY_PRESS_CLASSIFIER_MACROS_SVH
`define KEY_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define KPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key_press_classifier: implication check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define KPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key_press_classifier: next-cycle check failed");

`endif

FILE: src/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg
// Types and constants shared by the key press classifier modules.
// ----------------------------------------------------------------------------
package kpc_pkg;

   // Number of keys handled in parallel.
   localparam int NUM_KEYS = 4;

   // Fixed field widths.
   localparam int LEVELS_W = 4;   // key level field and event fields
   localparam int PRESS_W  = 16;  // press counter and long threshold
   localparam int WINDOW_W = 8;   // double-click window counter and length

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_WINDOW = 2'd1;

   // Register reset values.
   localparam logic [PRESS_W-1:0]  LONG_PRESS_RESET    = 16'd100;
   localparam logic [WINDOW_W-1:0] DOUBLE_WINDOW_RESET = 8'd20;

   // Per-key press machine.
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_SEEN    = 2'd1,
      PH_PRESSED = 2'd2
   } kpc_phase_type;

   // Events one key decides in one tick.
   typedef struct packed {
      logic single;
      logic dbl;
      logic lng;
   } kpc_event_type;

endpackage

FILE: src/kpc_lane.sv
// ----------------------------------------------------------------------------
// kpc_lane
// One key's press machine: debounce, press timing, double-click window and
// event decision. One transaction per cycle while enabled.
// ----------------------------------------------------------------------------
module kpc_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         pressed,
   input  logic [kpc_pkg::PRESS_W-1:0]  long_ticks,
   input  logic [kpc_pkg::WINDOW_W-1:0] window_len,
   output kpc_pkg::kpc_event_type       event_out
);
   import kpc_pkg::*;

   kpc_phase_type       phase_ff, phase_in;
   logic [PRESS_W-1:0]  press_ticks_ff, press_ticks_in;
   logic [WINDOW_W-1:0] window_ticks_ff, window_ticks_in;
   logic                window_open_ff, window_open_in;

   logic [PRESS_W-1:0]  press_base;
   logic [WINDOW_W-1:0] window_sat;
   logic                is_short;
   logic                window_expire;
   logic                window_step;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_PRESSED: begin
            phase_in = pressed ? PH_PRESSED : PH_IDLE;
         end
         PH_SEEN: begin
            phase_in = pressed ? PH_PRESSED : PH_IDLE;
         end
         PH_IDLE: begin
            phase_in = pressed ? PH_SEEN : PH_IDLE;
         end
         default: begin
            phase_in = pressed ? PH_SEEN : PH_IDLE;
         end
      endcase
   end

   // Shared terms: short press test and saturating window count
   assign is_short      = press_ticks_ff < long_ticks;
   assign window_sat    = (window_ticks_ff == {WINDOW_W{1'b1}}) ?
                          window_ticks_ff : window_ticks_ff + 1'b1;
   assign window_expire = window_sat >= window_len;

   // Events and counter updates
   always_comb begin
      event_out       = '0;
      window_open_in  = window_open_ff;
      window_ticks_in = window_ticks_ff;
      press_base      = press_ticks_ff;
      window_step     = 1'b0;
      case (phase_ff)
         PH_PRESSED: begin
            if (!pressed) begin
               if (is_short) begin
                  if (window_open_ff) begin
                     window_open_in = 1'b0;
                     event_out.dbl  = 1'b1;
                  end else begin
                     window_open_in  = 1'b1;
                     window_ticks_in = '0;
                  end
               end else begin
                  event_out.lng = 1'b1;
               end
            end
         end
         PH_SEEN: begin
            window_step = !pressed;
         end
         PH_IDLE: begin
            if (pressed) begin
               press_base = '0;
            end
            window_step = !pressed;
         end
         default: begin
            if (pressed) begin
               press_base = '0;
            end
            window_step = !pressed;
         end
      endcase

      // Released tick with the window open
      if (window_step && window_open_ff) begin
         window_ticks_in = window_sat;
         if (window_expire) begin
            event_out.single = 1'b1;
            window_open_in   = 1'b0;
         end
      end

      // Press counter runs in the confirmed phase, saturating at the threshold
      press_ticks_in = press_base;
      if (phase_in == PH_PRESSED && press_base < long_ticks) begin
         press_ticks_in = press_base + 1'b1;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         press_ticks_ff  <= '0;
         window_ticks_ff <= '0;
         window_open_ff  <= 1'b0;
      end else if (enable) begin
         phase_ff        <= phase_in;
         press_ticks_ff  <= press_ticks_in;
         window_ticks_ff <= window_ticks_in;
         window_open_ff  <= window_open_in;
      end
   end

endmodule

FILE: src/kpc_merge.sv
// ----------------------------------------------------------------------------
// kpc_merge
// Packs the lanes' events into the result fields and holds them in an output
// register backed by a one-entry skid register.
// ----------------------------------------------------------------------------
module kpc_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  kpc_pkg::kpc_event_type        lane_events [kpc_pkg::NUM_KEYS],
   output logic                          full,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [kpc_pkg::LEVELS_W-1:0]  rsp_single_events,
   output logic [kpc_pkg::LEVELS_W-1:0]  rsp_double_events,
   output logic [kpc_pkg::LEVELS_W-1:0]  rsp_long_events
);
   import kpc_pkg::*;

   logic [LEVELS_W-1:0] single_bits, double_bits, long_bits;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEVELS_W-1:0] out_single_ff, out_double_ff, out_long_ff;
   logic                skid_valid_ff, skid_valid_in;
   logic [LEVELS_W-1:0] skid_single_ff, skid_double_ff, skid_long_ff;
   logic                out_take;
   logic                load_new;
   logic                load_skid;
   logic                park_new;

   // Gather lane events; keys past the field width are dropped
   for (genvar i = 0; i < LEVELS_W; i++) begin : g_pack
      if (i < NUM_KEYS) begin : g_key
         assign single_bits[i] = lane_events[i].single;
         assign double_bits[i] = lane_events[i].dbl;
         assign long_bits[i]   = lane_events[i].lng;
      end else begin : g_none
         assign single_bits[i] = 1'b0;
         assign double_bits[i] = 1'b0;
         assign long_bits[i]   = 1'b0;
      end
   end

   // Output register and skid control
   assign out_take  = rsp_valid_ff && !rsp_stall;
   assign load_new  = accept && (!rsp_valid_ff || out_take);
   assign park_new  = accept && rsp_valid_ff && !out_take;
   assign load_skid = skid_valid_ff && out_take;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_new || load_skid) begin
         rsp_valid_in = 1'b1;
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
      skid_valid_in = skid_valid_ff;
      if (park_new) begin
         skid_valid_in = 1'b1;
      end else if (load_skid) begin
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (load_new) begin
         out_single_ff <= single_bits;
         out_double_ff <= double_bits;
         out_long_ff   <= long_bits;
      end else if (load_skid) begin
         out_single_ff <= skid_single_ff;
         out_double_ff <= skid_double_ff;
         out_long_ff   <= skid_long_ff;
      end
      if (park_new) begin
         skid_single_ff <= single_bits;
         skid_double_ff <= double_bits;
         skid_long_ff   <= long_bits;
      end
   end

   assign full              = skid_valid_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_single_events = out_single_ff;
   assign rsp_double_events = out_double_ff;
   assign rsp_long_events   = out_long_ff;

endmodule

FILE: src/key_press_classifier.sv
// ----------------------------------------------------------------------------
// key_press_classifier
// Single, double and long press detection for a row of active-low keys.
// ----------------------------------------------------------------------------
// Each transaction is one tick of key levels; it yields exactly one result
// transaction of single, double and long event bits, registered when it is
// accepted. A new tick can be accepted every cycle that req_stall is low: each
// key has its own lane holding its press machine and counters, and all lanes
// update in the cycle the tick is accepted. Results sit in an output register
// with a one-entry skid register behind it, so req_stall rises only when both
// hold results, i.e. after a tick is taken while the output is held stalled.
// Write csr registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
`include "key_press_classifier_macros.svh"

module key_press_classifier (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [kpc_pkg::LEVELS_W-1:0]    req_key_levels,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [kpc_pkg::LEVELS_W-1:0]    rsp_single_events,
   output logic [kpc_pkg::LEVELS_W-1:0]    rsp_double_events,
   output logic [kpc_pkg::LEVELS_W-1:0]    rsp_long_events,
   input  logic                            csr_write_enable,
   input  logic [kpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kpc_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import kpc_pkg::*;

   logic [PRESS_W-1:0]  long_ticks_ff;
   logic [WINDOW_W-1:0] window_len_ff;
   logic                req_accept;
   logic                merge_full;
   logic [NUM_KEYS-1:0] key_pressed;
   kpc_event_type       lane_events [NUM_KEYS];
   logic [LEVELS_W-1:0] event_overlap;
   logic                park_accept;

   // Configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         long_ticks_ff <= LONG_PRESS_RESET;
         window_len_ff <= DOUBLE_WINDOW_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LONG_PRESS: begin
               long_ticks_ff <= csr_write_data[PRESS_W-1:0];
            end
            CSR_DOUBLE_WINDOW: begin
               window_len_ff <= csr_write_data[WINDOW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = merge_full;

   // One lane per key; keys beyond the level field read as pressed
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      if (k < LEVELS_W) begin : g_level
         assign key_pressed[k] = !req_key_levels[k];
      end else begin : g_low
         assign key_pressed[k] = 1'b1;
      end

      kpc_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .enable     (req_accept),
         .pressed    (key_pressed[k]),
         .long_ticks (long_ticks_ff),
         .window_len (window_len_ff),
         .event_out  (lane_events[k])
      );
   end

   // Merge lane events into the result transaction
   kpc_merge u_merge (
      .clock             (clock),
      .reset             (reset),
      .accept            (req_accept),
      .lane_events       (lane_events),
      .full              (merge_full),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_single_events (rsp_single_events),
      .rsp_double_events (rsp_double_events),
      .rsp_long_events   (rsp_long_events)
   );

   // Terms for the checks below
   assign event_overlap = (rsp_single_events & rsp_double_events) |
                          (rsp_single_events & rsp_long_events) |
                          (rsp_double_events & rsp_long_events);
   assign park_accept   = req_accept && rsp_valid && rsp_stall;

   // A key decides at most one event per tick
   `KPC_ASSERT_IMPL(a_one_event_per_key, clock, reset, rsp_valid, event_overlap == '0)
   // Skid register only fills behind a held output
   `KPC_ASSERT_IMPL(a_skid_behind_output, clock, reset, req_stall, rsp_valid)
   // A tick taken while the output is held stalled must park in the skid
   `KPC_ASSERT_NEXT(a_park_on_stall, clock, reset, park_accept, req_stall && rsp_valid)

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for key_press_classifier: drives tick transactions with
// random gaps and output stalls, predicts the single, double and long events
// of every key, and compares each result transaction in order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import kpc_pkg::*;

   // Spare register indexes; writes to them must have no effect.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int NUM_PHASES = 8;

   typedef struct packed {
      logic [LEVELS_W-1:0] single_bits;
      logic [LEVELS_W-1:0] double_bits;
      logic [LEVELS_W-1:0] long_bits;
   } tick_events_type;

   // Predicts the events of each tick and checks results in order.
   class click_scoreboard;
      logic [PRESS_W-1:0]  long_limit;
      logic [WINDOW_W-1:0] window_limit;
      kpc_phase_type       phase[NUM_KEYS];
      logic [PRESS_W-1:0]  held_ticks[NUM_KEYS];
      logic [WINDOW_W-1:0] gap_ticks[NUM_KEYS];
      bit                  window_open[NUM_KEYS];
      tick_events_type     expected_events[$];
      int                  errors;

      function new();
         long_limit   = LONG_PRESS_RESET;
         window_limit = DOUBLE_WINDOW_RESET;
         errors       = 0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            phase[k]       = PH_IDLE;
            held_ticks[k]  = '0;
            gap_ticks[k]   = '0;
            window_open[k] = 1'b0;
         end
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_LONG_PRESS)
            long_limit = data[PRESS_W-1:0];
         else if (idx == CSR_DOUBLE_WINDOW)
            window_limit = data[WINDOW_W-1:0];
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      // Advance every key machine by one accepted tick.
      function void note_tick(logic [LEVELS_W-1:0] levels);
         tick_events_type ev;
         bit              pressed;
         int              k;
         ev = '0;
         for (k = 0; k < NUM_KEYS; k++) begin
            pressed = (k < LEVELS_W) ? !levels[k] : 1'b1;
            if (pressed) begin
               case (phase[k])
                  PH_PRESSED: ;
                  PH_SEEN: phase[k] = PH_PRESSED;
                  default: begin
                     phase[k]      = PH_SEEN;
                     held_ticks[k] = '0;
                  end
               endcase
            end else if (phase[k] == PH_PRESSED) begin
               // release of a confirmed press
               if (held_ticks[k] < long_limit) begin
                  if (window_open[k]) begin
                     window_open[k] = 1'b0;
                     if (k < LEVELS_W) ev.double_bits[k] = 1'b1;
                  end else begin
                     window_open[k] = 1'b1;
                     gap_ticks[k]   = '0;
                  end
               end else if (k < LEVELS_W) begin
                  ev.long_bits[k] = 1'b1;
               end
               phase[k] = PH_IDLE;
            end else begin
               // key up: an open window counts, saturating
               phase[k] = PH_IDLE;
               if (window_open[k]) begin
                  if (gap_ticks[k] != '1) gap_ticks[k] = gap_ticks[k] + 1'b1;
                  if (gap_ticks[k] >= window_limit) begin
                     if (k < LEVELS_W) ev.single_bits[k] = 1'b1;
                     window_open[k] = 1'b0;
                  end
               end
            end
            if (phase[k] == PH_PRESSED && held_ticks[k] < long_limit)
               held_ticks[k] = held_ticks[k] + 1'b1;
         end
         expected_events.push_back(ev);
      endfunction

      function void check_result(logic [LEVELS_W-1:0] s, logic [LEVELS_W-1:0] d,
                                 logic [LEVELS_W-1:0] l);
         tick_events_type want;
         if (expected_events.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: result transaction with none expected: s=%h d=%h l=%h",
                        s, d, l);
            return;
         end
         want = expected_events.pop_front();
         if (want.single_bits !== s || want.double_bits !== d || want.long_bits !== l) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: events mismatch: expected s=%h d=%h l=%h, got s=%h d=%h l=%h",
                        want.single_bits, want.double_bits, want.long_bits, s, d, l);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [LEVELS_W-1:0]    req_key_levels;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [LEVELS_W-1:0]    rsp_single_events;
   logic [LEVELS_W-1:0]    rsp_double_events;
   logic [LEVELS_W-1:0]    rsp_long_events;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   click_scoreboard results = new();

   // stimulus knobs shared with the receiver process
   int                  req_idle_rate = 4;
   int                  rsp_idle_rate = 4;
   int                  hold_cycles   = 0;
   logic [PRESS_W-1:0]  long_cfg      = LONG_PRESS_RESET;
   logic [WINDOW_W-1:0] window_cfg    = DOUBLE_WINDOW_RESET;

   // per-key press/release script for the random part
   bit key_up[LEVELS_W];
   int span_left[LEVELS_W];

   key_press_classifier dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_key_levels    (req_key_levels),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_single_events (rsp_single_events),
      .rsp_double_events (rsp_double_events),
      .rsp_long_events   (rsp_long_events),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one tick; return once it is accepted.
   task automatic send_tick(input logic [LEVELS_W-1:0] levels);
      int gap;
      if (req_idle_rate != 0 && $urandom_range(1, req_idle_rate) == 1) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_key_levels <= levels;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      results.note_tick(levels);
   endtask

   // Drain the block, then write both thresholds and poke the spare indexes.
   task automatic apply_settings(input logic [PRESS_W-1:0] long_v,
                                 input logic [WINDOW_W-1:0] win_v);
      logic [CSR_DATA_W-1:0] data;
      req_valid <= 1'b0;
      while (results.pending() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_LONG_PRESS;
      csr_write_data   <= long_v;
      results.set_register(CSR_LONG_PRESS, long_v);
      @(posedge clock);
      data = {8'($urandom), win_v};
      csr_index      <= CSR_DOUBLE_WINDOW;
      csr_write_data <= data;
      results.set_register(CSR_DOUBLE_WINDOW, data);
      @(posedge clock);
      data = 16'($urandom);
      csr_index      <= CSR_SPARE_A;
      csr_write_data <= data;
      results.set_register(CSR_SPARE_A, data);
      @(posedge clock);
      data = 16'($urandom);
      csr_index      <= CSR_SPARE_B;
      csr_write_data <= data;
      results.set_register(CSR_SPARE_B, data);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      long_cfg   = long_v;
      window_cfg = win_v;
   endtask

   function automatic int pick_press_span();
      int top;
      top = (long_cfg > 60) ? 60 : ((long_cfg < 2) ? 2 : int'(long_cfg));
      case ($urandom_range(0, 5))
         0: return 1;                          // glitch: released while seen low
         1, 2: return $urandom_range(2, top);  // short press
         3: begin
            if (long_cfg <= 250)
               return $urandom_range(int'(long_cfg) + 1, int'(long_cfg) + 4);
            return $urandom_range(2, top);
         end
         default: return $urandom_range(1, top + 4);
      endcase
   endfunction

   function automatic int pick_release_span();
      case ($urandom_range(0, 4))
         0: return 1;
         1, 2: return $urandom_range(1, int'(window_cfg) + 1);
         default: return $urandom_range(int'(window_cfg) + 1, int'(window_cfg) + 6);
      endcase
   endfunction

   // Next tick of well-formed press/release runs, with occasional bit noise.
   function automatic logic [LEVELS_W-1:0] next_levels();
      logic [LEVELS_W-1:0] lv;
      int k;
      for (k = 0; k < LEVELS_W; k++) begin
         if (span_left[k] == 0) begin
            key_up[k]    = !key_up[k];
            span_left[k] = key_up[k] ? pick_release_span() : pick_press_span();
         end
         span_left[k]--;
         lv[k] = key_up[k];
      end
      if ($urandom_range(0, 9) == 0) lv ^= LEVELS_W'($urandom);
      return lv;
   endfunction

   // Result side: check accepted transactions, drive stall bursts.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            results.check_result(rsp_single_events, rsp_double_events, rsp_long_events);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_rate != 0 && $urandom_range(1, rsp_idle_rate) == 1) begin
            stall_left = $urandom_range(0, 9);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Main sequence: directed ticks, then random phases under varied settings.
   initial begin
      logic [PRESS_W-1:0]  phase_long[NUM_PHASES];
      logic [WINDOW_W-1:0] phase_window[NUM_PHASES];
      int                  phase_items[NUM_PHASES];
      int                  p;
      int                  n;
      int                  drain;
      phase_long   = '{16'd1, 16'd4, 16'd10, 16'd2, 16'd65535, 16'd100, 16'd7, 16'd3};
      phase_window = '{8'd1, 8'd3, 8'd8, 8'd255, 8'd5, 8'd20, 8'd2, 8'd4};
      phase_items  = '{60, 60, 60, 300, 60, 60, 60, 60};
      for (n = 0; n < LEVELS_W; n++) begin
         key_up[n]    = 1'b1;
         span_left[n] = 0;
      end
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_key_levels   <= '1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_LONG_PRESS;
      csr_write_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero long threshold: every confirmed release is long; glitch press
      apply_settings(16'd0, 8'd0);
      send_tick(4'hF);
      send_tick(4'h0);
      send_tick(4'h0);
      send_tick(4'hF);
      send_tick(4'h0);
      send_tick(4'hF);
      // zero window: single on the first released tick after a short press
      apply_settings(16'd3, 8'd0);
      send_tick(4'h0);
      send_tick(4'h0);
      send_tick(4'hF);
      send_tick(4'hF);
      // double click inside the window, then split halves of the row
      apply_settings(16'd3, 8'd2);
      send_tick(4'h0);
      send_tick(4'h0);
      send_tick(4'hF);
      send_tick(4'h0);
      send_tick(4'h0);
      send_tick(4'hF);
      send_tick(4'h5);
      send_tick(4'h5);
      send_tick(4'hA);
      send_tick(4'hA);
      send_tick(4'hF);

      // random phases; the last one runs with no idling on either side
      for (p = 0; p < NUM_PHASES; p++) begin
         apply_settings(phase_long[p], phase_window[p]);
         if (p == NUM_PHASES - 1) begin
            req_idle_rate = 0;
            rsp_idle_rate = 0;
         end else begin
            req_idle_rate = (p % 3 == 2) ? 0 : $urandom_range(2, 8);
            rsp_idle_rate = (p % 4 == 1) ? 0 : $urandom_range(2, 8);
         end
         for (n = 0; n < phase_items[p]; n++) begin
            if (p == 2 && n == 10) hold_cycles = 40;  // back up the block
            send_tick(next_levels());
         end
      end

      req_valid <= 1'b0;
      while (results.pending() != 0) @(posedge clock);
      for (drain = 0; drain < 5; drain++) @(posedge clock);
      if (results.errors == 0 && results.pending() == 0)
         $display("key_press_classifier test passed");
      else
         $display("key_press_classifier test failed");
      $finish;
   end

   // Run limit
   initial begin
      #2000000;
      $display("key_press_classifier test failed");
      $finish;
   end

endmodule
